[design/der_rsa_key_integer_parser_macros.svh]
// Assertion macros shared by the checker of the DER RSA key integer parser.
// Needs a clk_i and an rst_ni in the scope where a macro is used.
`ifndef DER_RSA_KEY_INTEGER_PARSER_MACROS_SVH
`define DER_RSA_KEY_INTEGER_PARSER_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define DRK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define DRK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[design/drk_pkg.sv]
// Package of the DER RSA key integer parser: phase and error codes,
// DER constants, the algorithm prefix table and the result type. No dependencies.
package drk_pkg;

  // Parser phases.
  typedef enum logic [3:0] {
    PH_SEQ_TAG  = 4'd0,
    PH_SEQ_LEN  = 4'd1,
    PH_VER_TAG  = 4'd2,
    PH_VER_LEN  = 4'd3,
    PH_VER_BYTE = 4'd4,
    PH_PREFIX   = 4'd5,
    PH_INT_TAG  = 4'd6,
    PH_INT_LEN  = 4'd7,
    PH_INT_PAD  = 4'd8,
    PH_INT_DATA = 4'd9,
    PH_TRAIL    = 4'd10
  } phase_e;

  // Error codes reported with the end of a key.
  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_TRUNCATED = 3'd1,
    ERR_NOT_SEQ   = 3'd2,
    ERR_LEN_MISM  = 3'd3,
    ERR_BAD_VER   = 3'd4,
    ERR_PREFIX    = 3'd5,
    ERR_INT_TAG   = 3'd6,
    ERR_INT_LONG  = 3'd7
  } err_e;

  // DER tags and lengths.
  localparam logic [7:0] TAG_SEQUENCE = 8'h30;
  localparam logic [7:0] TAG_INTEGER  = 8'h02;
  localparam logic [7:0] VER_LENGTH   = 8'h01;
  localparam logic [7:0] INT_LEN_PAD  = 8'h09;

  localparam int unsigned CountW    = 9;
  localparam int unsigned PrefixLen = 20;
  localparam int unsigned PrefixW   = 5;

  localparam logic [CountW-1:0] COUNT_MAX      = 9'd511;
  localparam logic [CountW-1:0] MIN_COUNT_PRIV = 9'd5;
  localparam logic [CountW-1:0] MIN_COUNT_PUB  = 9'd22;
  localparam logic [3:0]        INTS_PRIV      = 4'd8;
  localparam logic [3:0]        INTS_PUB       = 4'd2;
  localparam logic [PrefixW-1:0] PREFIX_END    = 5'd20;

  // Fixed algorithm prefix of a public key.
  function automatic logic [7:0] alg_prefix(input logic [PrefixW-1:0] pos);
    logic [7:0] b;
    case (pos)
      5'd0:    b = 8'h30;
      5'd1:    b = 8'h0D;
      5'd2:    b = 8'h06;
      5'd3:    b = 8'h09;
      5'd4:    b = 8'h2A;
      5'd5:    b = 8'h86;
      5'd6:    b = 8'h48;
      5'd7:    b = 8'h86;
      5'd8:    b = 8'hF7;
      5'd9:    b = 8'h0D;
      5'd10:   b = 8'h01;
      5'd11:   b = 8'h01;
      5'd12:   b = 8'h01;
      5'd13:   b = 8'h05;
      5'd14:   b = 8'h00;
      5'd15:   b = 8'h03;
      5'd16:   b = 8'h13;
      5'd17:   b = 8'h00;
      5'd18:   b = 8'h30;
      5'd19:   b = 8'h10;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // One result request.
  typedef struct packed {
    logic        value_valid;
    logic [63:0] int_value;
    logic [2:0]  value_index;
    logic        done_res;
    logic [2:0]  error_code;
  } res_t;

endpackage

[design/drk_if.sv]
// Valid/ready channels of the DER RSA key integer parser: the byte input
// and the result output. No dependencies.
interface drk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface drk_res_if;
  logic        valid;
  logic        ready;
  logic        value_valid;
  logic [63:0] int_value;
  logic [2:0]  value_index;
  logic        done_res;
  logic [2:0]  error_code;

  modport source (output valid, output value_valid, output int_value, output value_index,
                  output done_res, output error_code, input ready);
  modport sink (input valid, input value_valid, input int_value, input value_index,
                input done_res, input error_code, output ready);
endinterface

[design/der_rsa_key_integer_parser.sv]
// Each result is registered in out_q when its byte is accepted, or in the skid stage while res_o stalls.
// Throughput: one byte per cycle when the skid stage is free; the parser state is updated in the accepting cycle.
// A two-deep result register and skid stage keep input taken while one result waits.
// Reset (rst_ni low, asynchronous) rearms the parser, clears key_mode to private
// and empties both result stages.
module der_rsa_key_integer_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  drk_in_if.sink       in_i,
  drk_res_if.source    res_o
);
  import drk_pkg::*;

  // Configuration and parser state.
  logic                key_mode_q;
  phase_e              phase_q, phase_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [7:0]          seq_len_q, seq_len_d;
  logic [63:0]         acc_q, acc_d;
  logic [3:0]          remain_q, remain_d;
  logic [3:0]          int_cnt_q, int_cnt_d;
  logic [PrefixW-1:0]  prefix_pos_q, prefix_pos_d;
  logic                err_seen_q, err_seen_d;

  // Result stages.
  res_t   out_q, out_d, skid_q, skid_d, res_new;
  logic   out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  logic   accept, gen;

  assign in_i.ready = ~skid_vld_q;
  assign accept     = in_i.valid & in_i.ready;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      key_mode_q <= cfg_wdata_i;
    end
  end

  // Byte parser: next state and the result of the current byte.
  always_comb begin
    logic [7:0]        b;
    logic              last;
    logic              emit;
    logic              err;
    err_e              code;
    logic [CountW-1:0] min_count;
    logic [3:0]        total;
    logic [63:0]       shifted;

    b         = in_i.data_byte;
    last      = in_i.last_byte;
    emit      = 1'b0;
    err       = 1'b0;
    code      = ERR_OK;
    min_count = key_mode_q ? MIN_COUNT_PUB : MIN_COUNT_PRIV;
    total     = key_mode_q ? INTS_PUB : INTS_PRIV;
    shifted   = {acc_q[55:0], b};

    phase_d      = phase_q;
    count_d      = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
    seq_len_d    = seq_len_q;
    acc_d        = acc_q;
    remain_d     = remain_q;
    int_cnt_d    = int_cnt_q;
    prefix_pos_d = prefix_pos_q;
    err_seen_d   = err_seen_q;
    res_new      = '0;
    gen          = 1'b0;

    if (!err_seen_q) begin
      case (phase_q)
        PH_SEQ_TAG: begin
          if (b != TAG_SEQUENCE) begin
            err = 1'b1; code = ERR_NOT_SEQ;
          end else begin
            phase_d = PH_SEQ_LEN;
          end
        end
        PH_SEQ_LEN: begin
          seq_len_d    = b;
          phase_d      = key_mode_q ? PH_PREFIX : PH_VER_TAG;
          prefix_pos_d = '0;
        end
        PH_VER_TAG: begin
          if (b != TAG_INTEGER) begin
            err = 1'b1; code = ERR_BAD_VER;
          end else begin
            phase_d = PH_VER_LEN;
          end
        end
        PH_VER_LEN: begin
          if (b != VER_LENGTH) begin
            err = 1'b1; code = ERR_BAD_VER;
          end else begin
            phase_d = PH_VER_BYTE;
          end
        end
        PH_VER_BYTE: begin
          phase_d = PH_INT_TAG;
        end
        PH_PREFIX: begin
          if (prefix_pos_q >= PREFIX_END || b != alg_prefix(prefix_pos_q)) begin
            err = 1'b1; code = ERR_PREFIX;
          end else begin
            prefix_pos_d = prefix_pos_q + 1'b1;
            if (prefix_pos_d == PREFIX_END) phase_d = PH_INT_TAG;
          end
        end
        PH_INT_TAG: begin
          if (b != TAG_INTEGER) begin
            err = 1'b1; code = ERR_INT_TAG;
          end else begin
            phase_d = PH_INT_LEN;
          end
        end
        PH_INT_LEN: begin
          acc_d = '0;
          if (b > INT_LEN_PAD) begin
            err = 1'b1; code = ERR_INT_LONG;
          end else if (b == INT_LEN_PAD) begin
            remain_d = 4'd8;
            phase_d  = PH_INT_PAD;
          end else if (b == 8'd0) begin
            emit = 1'b1;
          end else begin
            remain_d = b[3:0];
            phase_d  = PH_INT_DATA;
          end
        end
        PH_INT_PAD: begin
          if (b != 8'h00) begin
            err = 1'b1; code = ERR_INT_LONG;
          end else begin
            phase_d = PH_INT_DATA;
          end
        end
        PH_INT_DATA: begin
          acc_d = shifted;
          if (remain_q != 4'd0) remain_d = remain_q - 1'b1;
          if (remain_d == 4'd0) emit = 1'b1;
        end
        PH_TRAIL: begin
        end
        default: begin
          phase_d = PH_SEQ_TAG;
          err = 1'b1; code = ERR_NOT_SEQ;
        end
      endcase

      // A completed integer is handed out and the next one is awaited, or the trailer phase follows the last integer.
      if (emit) begin
        res_new.value_valid = 1'b1;
        res_new.int_value   = acc_d;
        res_new.value_index = int_cnt_q[2:0];
        int_cnt_d           = int_cnt_q + 1'b1;
        acc_d               = '0;
        phase_d             = (int_cnt_d >= total) ? PH_TRAIL : PH_INT_TAG;
      end

      if (err) begin
        res_new            = '0;
        res_new.done_res   = 1'b1;
        res_new.error_code = code;
        gen                = 1'b1;
        err_seen_d         = ~last;
      end else if (last) begin
        // End-of-key checks, in order of precedence.
        if (count_d < min_count) begin
          code = ERR_TRUNCATED;
        end else if ({1'b0, seq_len_d} + 9'd2 != count_d) begin
          code = ERR_LEN_MISM;
        end else if (phase_d != PH_TRAIL) begin
          code = ERR_TRUNCATED;
        end else begin
          code = ERR_OK;
        end
        res_new.done_res   = 1'b1;
        res_new.error_code = code;
        gen                = 1'b1;
      end else begin
        gen = emit;
      end
    end

    // The last byte of a key rearms the parser.
    if (last) begin
      phase_d      = PH_SEQ_TAG;
      count_d      = '0;
      seq_len_d    = '0;
      acc_d        = '0;
      remain_d     = '0;
      int_cnt_d    = '0;
      prefix_pos_d = '0;
      err_seen_d   = 1'b0;
    end
  end

  // Parser state registers, updated on each accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_SEQ_TAG;
      count_q      <= '0;
      seq_len_q    <= '0;
      acc_q        <= '0;
      remain_q     <= '0;
      int_cnt_q    <= '0;
      prefix_pos_q <= '0;
      err_seen_q   <= 1'b0;
    end else if (accept) begin
      phase_q      <= phase_d;
      count_q      <= count_d;
      seq_len_q    <= seq_len_d;
      acc_q        <= acc_d;
      remain_q     <= remain_d;
      int_cnt_q    <= int_cnt_d;
      prefix_pos_q <= prefix_pos_d;
      err_seen_q   <= err_seen_d;
    end
  end

  // Result register with a skid stage behind it.
  always_comb begin
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    skid_d     = skid_q;
    skid_vld_d = skid_vld_q;
    if (!out_vld_q || res_o.ready) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end else begin
        out_d     = res_new;
        out_vld_d = accept & gen;
      end
    end else if (accept && gen) begin
      skid_d     = res_new;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  // Result channel.
  assign res_o.valid       = out_vld_q;
  assign res_o.value_valid = out_q.value_valid;
  assign res_o.int_value   = out_q.int_value;
  assign res_o.value_index = out_q.value_index;
  assign res_o.done_res    = out_q.done_res;
  assign res_o.error_code  = out_q.error_code;

endmodule

[design/drk_checker.sv]
// Port-level checker of the DER RSA key integer parser and its bind.
// Depends on der_rsa_key_integer_parser_macros.svh, drk_pkg and the top level's ports.
`include "der_rsa_key_integer_parser_macros.svh"

module drk_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic        value_valid_i,
  input logic [63:0] int_value_i,
  input logic [2:0]  value_index_i,
  input logic        done_res_i,
  input logic [2:0]  error_code_i
);
  import drk_pkg::*;

  // Views of the result request that keep the assertions short.
  logic        plain_value;
  logic        done_only;
  logic        res_stalled;
  logic        value_fields_zero;
  logic [71:0] res_payload;

  assign plain_value       = res_valid_i && !done_res_i;
  assign done_only         = res_valid_i && !value_valid_i;
  assign res_stalled       = res_valid_i && !res_ready_i;
  assign value_fields_zero = (int_value_i == 64'd0) && (value_index_i == 3'd0);
  assign res_payload       = {value_valid_i, int_value_i, value_index_i, done_res_i,
                              error_code_i};

  // Every result request carries a value, an end-of-key report or both.
  `DRK_ASSERT(a_res_not_empty, res_valid_i |-> (value_valid_i || done_res_i), "empty result")

  // An error code only accompanies the end of a key.
  `DRK_ASSERT(a_code_needs_done, plain_value |-> (error_code_i == ERR_OK), "stray code")

  // Without a value, the value fields read as zero.
  `DRK_ASSERT(a_no_value_zero, done_only |-> value_fields_zero, "stray value")

  // A stalled result request holds.
  `DRK_ASSERT(a_res_hold, res_stalled |=> (res_valid_i && $stable(res_payload)), "lost result")

endmodule

bind der_rsa_key_integer_parser drk_checker u_drk_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .value_valid_i (res_o.value_valid),
  .int_value_i   (res_o.int_value),
  .value_index_i (res_o.value_index),
  .done_res_i    (res_o.done_res),
  .error_code_i  (res_o.error_code)
);
